FILE: rtl/life_generation_stencil_macros.svh
// Assertion macros shared by the life generation stencil RTL.
`ifndef LIFE_GENERATION_STENCIL_MACROS_SVH
`define LIFE_GENERATION_STENCIL_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LGS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lgs_pkg.sv
// Types, constants and the B3/S23 rule shared by the life generation stencil.
`default_nettype none
package lgs_pkg;

  // Field widths of the configuration registers.
  localparam int ColWidth = 10;
  localparam int RowWidth = 16;

  // Reset values of the configuration registers.
  localparam logic [ColWidth-1:0] InnerColumnsReset = ColWidth'(62);
  localparam logic [RowWidth-1:0] InnerRowsReset    = RowWidth'(62);

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_INNER_COLUMNS = 1'b0,
    REG_INNER_ROWS    = 1'b1
  } reg_idx_e;

  // One column of the 3x3 window; bit 0 is the oldest row.
  typedef logic [2:0] column_t;

  // Control that travels with an item through the window stage.
  typedef struct packed {
    logic produce;
    logic last;
  } item_flags_t;

  // Next state of the window centre: born with three neighbors, survives with two.
  function automatic logic life_next(input logic [8:0] win);
    logic [3:0] sum;
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        sum = sum + 4'(win[i]);
      end
    end
    return (sum == 4'd3) || (win[4] && (sum == 4'd2));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lgs_line_store.sv
// Line store for the two previous padded rows, one 2-bit entry per column.
`default_nettype none
module lgs_line_store #(
  parameter int Depth = 1024,
  parameter int AddrWidth = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AddrWidth-1:0] rd_addr_i,
  output logic      [1:0]           rd_data_o,  // bit 0 upper row, bit 1 middle row
  input  wire logic                 wr_en_i,
  input  wire logic [AddrWidth-1:0] wr_addr_i,
  input  wire logic [1:0]           wr_data_i   // bit 0 upper row, bit 1 middle row
);

  logic [1:0] mem_q [Depth];
  logic [1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/lgs_cell.sv
// One window column cell; it takes its neighbor's column on every shift.
`default_nettype none
module lgs_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_en_i,
  input  wire lgs_pkg::column_t col_i,
  output lgs_pkg::column_t     col_o
);
  import lgs_pkg::*;

  column_t col_q;
  column_t col_d;

  // Take the neighbor's column when the window moves.
  always_comb begin
    col_d = col_q;
    if (shift_en_i) begin
      col_d = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule
`default_nettype wire

FILE: rtl/life_generation_stencil.sv
// Top level of the B3/S23 life generation stencil over one halo-padded tile.
//
//  channel   | direction | handshake                       | payload
//  s_axis    | in        | s_axis_tvalid_i/s_axis_tready_o | tdata[0] cell_alive
//  m_axis    | out       | m_axis_tvalid_o/m_axis_tready_i | tdata[0] next_alive, tlast
//  apb       | in        | psel/penable/pwrite, pready     | paddr, pwdata, prdata
//
// One cell is taken per clock while m_axis does not stall. Its line-store read completes at
// the accepting edge, the cell then waits in the window stage, and its result is registered
// in the output register when the window stage advances.
// The line store has a separate read and write port, so back-to-back cells never wait.
// Reset clears counters, the window and all valid flags; line stores need no clearing.
// A stall on m_axis holds the window stage; s_axis stops once that stage is also full.
`default_nettype none
`include "life_generation_stencil_macros.svh"
module life_generation_stencil #(
  parameter int MAX_PADDED_COLUMNS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input cells.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [0] cell_alive, [7:1] zero
  // Results.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,   // [0] next_alive, [7:1] zero
  output logic             m_axis_tlast_o,   // frame_last
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import lgs_pkg::*;

  localparam int CW = $clog2(MAX_PADDED_COLUMNS);
  localparam int XW = ((CW > ColWidth) ? CW : ColWidth) + 1;
  localparam logic [XW-1:0] MaxInner = XW'(MAX_PADDED_COLUMNS - 2);

  // Configuration registers.
  logic [ColWidth-1:0] inner_columns_q, inner_columns_d;
  logic [RowWidth-1:0] inner_rows_q, inner_rows_d;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  // Position counters.
  logic [CW-1:0]       col_q, col_d;
  logic [RowWidth-1:0] row_q, row_d;
  logic [CW-1:0]       last_col;
  logic [RowWidth-1:0] last_row;
  logic [XW-1:0]       cols_ext, cols_clamped;
  logic [RowWidth-1:0] rows_clamped;

  // Window stage.
  logic                s1_valid_q, s1_valid_d;
  item_flags_t         s1_q, s1_d;
  logic                s1_cell_q;
  logic [CW-1:0]       s1_addr_q;
  logic                s1_adv;
  logic                in_acc;
  logic [1:0]          rd_data;
  column_t             cell_in [3];
  column_t             cell_out [3];
  logic [8:0]          new_win;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic                out_next_q;
  logic                out_last_q;
  logic                out_free;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    inner_columns_d = inner_columns_q;
    inner_rows_d    = inner_rows_q;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_INNER_COLUMNS: inner_columns_d = pwdata[ColWidth-1:0];
        REG_INNER_ROWS:    inner_rows_d    = pwdata[RowWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INNER_COLUMNS: prdata = 32'(inner_columns_q);
      REG_INNER_ROWS:    prdata = 32'(inner_rows_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_columns_q <= InnerColumnsReset;
      inner_rows_q    <= InnerRowsReset;
    end else begin
      inner_columns_q <= inner_columns_d;
      inner_rows_q    <= inner_rows_d;
    end
  end

  // Last padded column and row after clamping the interior sizes.
  always_comb begin
    cols_ext = XW'(inner_columns_q);
    if (inner_columns_q == '0) begin
      cols_clamped = XW'(1);
    end else if (cols_ext > MaxInner) begin
      cols_clamped = MaxInner;
    end else begin
      cols_clamped = cols_ext;
    end
    last_col = CW'(cols_clamped + XW'(1));

    if (inner_rows_q == '0) begin
      rows_clamped = RowWidth'(1);
    end else if (inner_rows_q == '1) begin
      rows_clamped = RowWidth'(65534);
    end else begin
      rows_clamped = inner_rows_q;
    end
    last_row = rows_clamped + RowWidth'(1);
  end

  // Handshake between the stages.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Raster counters and the interior test of the accepted cell.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_q >= last_col) begin
        col_d = '0;
        row_d = (row_q >= last_row) ? '0 : row_q + RowWidth'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    s1_d.produce = (row_q >= RowWidth'(2)) && (col_q >= CW'(2)) &&
                   (row_q <= last_row) && (col_q <= last_col);
    s1_d.last    = (row_q == last_row) && (col_q == last_col);
    s1_valid_d   = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q      <= s1_d;
      s1_cell_q <= s_axis_tdata_i[0];
      s1_addr_q <= col_q;
    end
  end

  // Line store: read at acceptance, rotate the rows when the window moves.
  lgs_line_store #(
    .Depth     (MAX_PADDED_COLUMNS),
    .AddrWidth (CW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({s1_cell_q, rd_data[1]})
  );

  // Chain of window column cells; the newest column enters at cell 2.
  assign cell_in[2] = {s1_cell_q, rd_data[1], rd_data[0]};
  assign cell_in[1] = cell_out[2];
  assign cell_in[0] = cell_out[1];

  for (genvar g = 0; g < 3; g++) begin : g_cell
    lgs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (s1_adv),
      .col_i      (cell_in[g]),
      .col_o      (cell_out[g])
    );
  end

  // Window after the shift, bit row*3+col.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        new_win[r*3+c] = cell_in[c][r];
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_q.produce;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.produce) begin
      out_next_q <= life_next(new_win);
      out_last_q <= s1_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_next_q};
  assign m_axis_tlast_o  = out_last_q;

  // A full window stage behind a blocked output must stall the input.
  `LGS_ASSERT_SAME(a_stall_input, clk_i, rst_ni,
                   s1_valid_q && out_valid_q && !m_axis_tready_i, !s_axis_tready_o,
                   "input accepted while the window stage is blocked")
  // An accepted cell always lands in the window stage.
  `LGS_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_acc, s1_valid_q,
                   "accepted cell missing from the window stage")
  // Line-store read data must hold while its cell waits in the window stage.
  `LGS_ASSERT_NEXT(a_read_hold, clk_i, rst_ni, s1_valid_q && !s1_adv, $stable(rd_data),
                   "line-store data changed under a waiting cell")

endmodule
`default_nettype wire
